### src/aolr_pkg.sv
// ----------------------------------------------------------------------------
// aolr_pkg: shared definitions for the all-octant line rasterizer
// Coordinate, decision-term and colour widths, and the operation codes.
// ----------------------------------------------------------------------------
package aolr_pkg;

   localparam int COORD_BITS = 12;
   localparam int TERM_BITS  = COORD_BITS + 4;
   localparam int COLOR_BITS = 24;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [TERM_BITS-1:0]  term_type;
   typedef logic [COLOR_BITS-1:0]        color_type;

endpackage

### src/aolr_channels.sv
// ----------------------------------------------------------------------------
// aolr channels: valid/ready interfaces for line requests and pixel responses
// Each interface carries the handshake pair and the payload fields by name.
// ----------------------------------------------------------------------------
interface aolr_req_if import aolr_pkg::*; ();
   logic      valid;
   logic      ready;
   op_type    op;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;
   color_type color;

   modport source (output valid, op, start_x, start_y, end_x, end_y, color, input ready);
   modport sink   (input valid, op, start_x, start_y, end_x, end_y, color, output ready);
endinterface

interface aolr_rsp_if import aolr_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type pixel_x;
   coord_type pixel_y;
   color_type pixel_color;
   logic      pixel_valid;
   logic      last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_color, pixel_valid, last_pixel,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, pixel_valid, last_pixel,
                   output ready);
endinterface

### src/all_octant_line_rasterizer.sv
// ----------------------------------------------------------------------------
// all_octant_line_rasterizer: midpoint line rasterizer for all eight octants
// A load item sets up a line and returns its first pixel; each step item
// returns the next pixel, with the final one of the line flagged.
// ----------------------------------------------------------------------------
// An accepted item's pixel is in the response register in the cycle after the accept.
// Throughput: one item per cycle while the response is taken; each step is one add
// and compare. The response register is refilled in the same cycle it is emptied.
// Reset: synchronous, active high; clears the line state and the response valid.
// After reset no line is active, so a step item returns an all-zero item.
module all_octant_line_rasterizer import aolr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   aolr_req_if.sink   req_chan,
   aolr_rsp_if.source rsp_chan
);

   // Line state. The stored pixel is always the one most recently emitted, and
   // the decision term is the one that chooses the step towards the next pixel.
   // line_active_ff is high while the line still has pixels to give.
   coord_type cur_x_ff, cur_x_in;
   coord_type cur_y_ff, cur_y_in;
   coord_type major_end_ff, major_end_in;
   term_type  decision_ff, decision_in;
   term_type  inc_move_ff, inc_move_in;
   term_type  inc_stay_ff, inc_stay_in;
   logic      steep_ff, steep_in;
   logic      negative_ff, negative_in;
   logic      line_active_ff, line_active_in;
   color_type line_color_ff, line_color_in;

   // Response register.
   logic      rsp_valid_ff, rsp_valid_in;
   coord_type rsp_x_ff, rsp_x_in;
   coord_type rsp_y_ff, rsp_y_in;
   color_type rsp_color_ff, rsp_color_in;
   logic      rsp_pixel_valid_ff, rsp_pixel_valid_in;
   logic      rsp_last_ff, rsp_last_in;

   logic accept;

   // The response register can take a new item whenever it is empty or is
   // being emptied in this same cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // Setup for a new line: order the endpoints along the major axis and
   // derive the decision term with its two increments.
   term_type sx, sy, ex, ey;
   term_type raw_dx, raw_dy, abs_dx, abs_dy;
   term_type x0, y0, x1, y1, dx, dy;
   logic     ld_steep, ld_swap, ld_negative, ld_last;
   term_type ld_decision, ld_inc_move, ld_inc_stay;

   always_comb begin
      sx     = TERM_BITS'(req_chan.start_x);
      sy     = TERM_BITS'(req_chan.start_y);
      ex     = TERM_BITS'(req_chan.end_x);
      ey     = TERM_BITS'(req_chan.end_y);
      raw_dx = ex - sx;
      raw_dy = ey - sy;
      abs_dx = raw_dx[TERM_BITS-1] ? -raw_dx : raw_dx;
      abs_dy = raw_dy[TERM_BITS-1] ? -raw_dy : raw_dy;
      // A slope of exactly plus or minus one is treated as shallow.
      ld_steep = abs_dy > abs_dx;
      ld_swap  = ld_steep ? (sy > ey) : (sx > ex);
      x0 = ld_swap ? ex : sx;
      y0 = ld_swap ? ey : sy;
      x1 = ld_swap ? sx : ex;
      y1 = ld_swap ? sy : ey;
      dx = x1 - x0;
      dy = y1 - y0;
      if (!ld_steep) begin
         ld_negative = dy[TERM_BITS-1];
         ld_inc_stay = -(dy + dy);
         if (!ld_negative) begin
            ld_decision = dx - (dy + dy);
            ld_inc_move = (dx + dx) - (dy + dy);
         end else begin
            ld_decision = -dx - (dy + dy);
            ld_inc_move = -(dx + dx) - (dy + dy);
         end
         ld_last = x0 >= x1;
      end else begin
         ld_negative = dx[TERM_BITS-1];
         ld_inc_stay = dx + dx;
         if (!ld_negative) begin
            ld_decision = (dx + dx) - dy;
            ld_inc_move = (dx + dx) - (dy + dy);
         end else begin
            ld_decision = (dx + dx) + dy;
            ld_inc_move = (dx + dx) + (dy + dy);
         end
         ld_last = y0 >= y1;
      end
   end

   // One step along the active line. Shallow lines step the minor axis when
   // the term is below zero (rising) or not below zero (falling); steep lines
   // when it is above zero (rightward) or not above zero (leftward).
   logic      dec_neg, dec_zero, st_move, st_last;
   coord_type minor_x, minor_y, st_x, st_y;
   term_type  st_decision;

   always_comb begin
      dec_neg  = decision_ff[TERM_BITS-1];
      dec_zero = (decision_ff == '0);
      if (!steep_ff) begin
         st_move = negative_ff ? !dec_neg : dec_neg;
      end else begin
         st_move = negative_ff ? (dec_neg || dec_zero) : (!dec_neg && !dec_zero);
      end
      minor_x = negative_ff ? cur_x_ff - COORD_BITS'(1) : cur_x_ff + COORD_BITS'(1);
      minor_y = negative_ff ? cur_y_ff - COORD_BITS'(1) : cur_y_ff + COORD_BITS'(1);
      if (!steep_ff) begin
         st_x    = cur_x_ff + COORD_BITS'(1);
         st_y    = st_move ? minor_y : cur_y_ff;
         st_last = st_x >= major_end_ff;
      end else begin
         st_x    = st_move ? minor_x : cur_x_ff;
         st_y    = cur_y_ff + COORD_BITS'(1);
         st_last = st_y >= major_end_ff;
      end
      st_decision = decision_ff + (st_move ? inc_move_ff : inc_stay_ff);
   end

   // Next-state selection.
   always_comb begin
      cur_x_in           = cur_x_ff;
      cur_y_in           = cur_y_ff;
      major_end_in       = major_end_ff;
      decision_in        = decision_ff;
      inc_move_in        = inc_move_ff;
      inc_stay_in        = inc_stay_ff;
      steep_in           = steep_ff;
      negative_in        = negative_ff;
      line_active_in     = line_active_ff;
      line_color_in      = line_color_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_chan.ready;
      rsp_x_in           = rsp_x_ff;
      rsp_y_in           = rsp_y_ff;
      rsp_color_in       = rsp_color_ff;
      rsp_pixel_valid_in = rsp_pixel_valid_ff;
      rsp_last_in        = rsp_last_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (req_chan.op == OP_LOAD) begin
            // A load abandons any line in progress.
            cur_x_in           = COORD_BITS'(x0);
            cur_y_in           = COORD_BITS'(y0);
            major_end_in       = ld_steep ? COORD_BITS'(y1) : COORD_BITS'(x1);
            decision_in        = ld_decision;
            inc_move_in        = ld_inc_move;
            inc_stay_in        = ld_inc_stay;
            steep_in           = ld_steep;
            negative_in        = ld_negative;
            line_active_in     = !ld_last;
            line_color_in      = req_chan.color;
            rsp_x_in           = COORD_BITS'(x0);
            rsp_y_in           = COORD_BITS'(y0);
            rsp_color_in       = req_chan.color;
            rsp_pixel_valid_in = 1'b1;
            rsp_last_in        = ld_last;
         end else if (line_active_ff) begin
            cur_x_in           = st_x;
            cur_y_in           = st_y;
            decision_in        = st_decision;
            line_active_in     = !st_last;
            rsp_x_in           = st_x;
            rsp_y_in           = st_y;
            rsp_color_in       = line_color_ff;
            rsp_pixel_valid_in = 1'b1;
            rsp_last_in        = st_last;
         end else begin
            // No line to draw: the item comes back with every field zero.
            rsp_x_in           = '0;
            rsp_y_in           = '0;
            rsp_color_in       = '0;
            rsp_pixel_valid_in = 1'b0;
            rsp_last_in        = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         major_end_ff   <= '0;
         decision_ff    <= '0;
         inc_move_ff    <= '0;
         inc_stay_ff    <= '0;
         steep_ff       <= 1'b0;
         negative_ff    <= 1'b0;
         line_active_ff <= 1'b0;
         line_color_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         major_end_ff   <= major_end_in;
         decision_ff    <= decision_in;
         inc_move_ff    <= inc_move_in;
         inc_stay_ff    <= inc_stay_in;
         steep_ff       <= steep_in;
         negative_ff    <= negative_in;
         line_active_ff <= line_active_in;
         line_color_ff  <= line_color_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff           <= rsp_x_in;
      rsp_y_ff           <= rsp_y_in;
      rsp_color_ff       <= rsp_color_in;
      rsp_pixel_valid_ff <= rsp_pixel_valid_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_x     = rsp_x_ff;
   assign rsp_chan.pixel_y     = rsp_y_ff;
   assign rsp_chan.pixel_color = rsp_color_ff;
   assign rsp_chan.pixel_valid = rsp_pixel_valid_ff;
   assign rsp_chan.last_pixel  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // The item on display was produced by the latest accept, so it agrees
   // with the line state left behind.
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> !line_active_ff)
      else $error("line still active after its final pixel");

   a_idle_stays_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pixel_valid_ff |-> !line_active_ff)
      else $error("empty item returned while a line is active");

   a_mid_line_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pixel_valid_ff && !rsp_last_ff |-> line_active_ff)
      else $error("line dropped before its final pixel");

   a_major_in_range: assert property (@(posedge clock) disable iff (reset)
      line_active_ff |-> (steep_ff ? (cur_y_ff < major_end_ff)
                                   : (cur_x_ff < major_end_ff)))
      else $error("major coordinate reached its end on an active line");
`endif

endmodule
